@@ hw/rtl/stopwatch_with_running_stats_defines.svh @@
// ============================================================================
// Stopwatch assertion macros
// Shared wrappers for the concurrent checks on the stopwatch ports.
// ============================================================================
`ifndef STOPWATCH_WITH_RUNNING_STATS_DEFINES_SVH
`define STOPWATCH_WITH_RUNNING_STATS_DEFINES_SVH

// Clocked check, switched off while reset is applied.
`define SWS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/sws_pkg.sv @@
// ============================================================================
// Stopwatch package
// Field widths, event codes, sequencer states and fixed constants.
// ============================================================================
package sws_pkg;

    // Input fields
    localparam int OPCODE_BITS  = 3;
    localparam int SECS_BITS    = 17;
    localparam int MICROS_BITS  = 20;
    localparam int IN_DATA_BITS = ((SECS_BITS + MICROS_BITS + 7) / 8) * 8;

    // Output fields
    localparam int OUT_ELAPSED_BITS = 32;
    localparam int MEAN_BITS        = 40;
    localparam int SQUARE_BITS      = 64;
    localparam int COUNT_BITS       = 32;
    localparam int OUT_RAW_BITS     = 1 + OUT_ELAPSED_BITS + MEAN_BITS + SQUARE_BITS
                                      + COUNT_BITS;
    localparam int OUT_DATA_BITS    = ((OUT_RAW_BITS + 7) / 8) * 8;

    // Interval arithmetic
    localparam int SECS_DIFF_BITS   = SECS_BITS + 2;
    localparam int MICROS_DIFF_BITS = MICROS_BITS + 1;
    localparam int SPAN_CALC_BITS   = 40;
    localparam int SPAN_BITS        = 37;

    localparam logic signed [SECS_DIFF_BITS-1:0] DAY_SECS    = 19'sd86400;
    localparam logic signed [SPAN_CALC_BITS-1:0] US_PER_SEC  = 40'sd1000000;

    // Divider sizes
    localparam int DIVIDEND_BITS = 64;
    localparam int DIVISOR_BITS  = COUNT_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

    localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_RESUME = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_APPLY,
        ST_MUL,
        ST_DIFF,
        ST_DIV,
        ST_FOLD,
        ST_DONE
    } fsm_state_t;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic span_en;
        logic apply_en;
        logic mul_start;
        logic div_start;
        logic fold_en;
        logic out_load;
    } sws_ctl_t;

endpackage

@@ hw/rtl/sws_serial_sqr.sv @@
// ============================================================================
// Bit-serial squarer
// Shift-add squaring of one operand, one multiplier bit per cycle.
// ============================================================================
module sws_serial_sqr #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   operand,
    output logic               done,
    output logic [2*WIDTH-1:0] product
);

    localparam int CNT_BITS = $clog2(WIDTH);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0]    a_reg, a_next;
    logic [2*WIDTH:0]    p_reg, p_next;
    logic [WIDTH:0]      addend;
    logic [WIDTH:0]      upper;

    // Add the operand into the upper half when the low bit is set, then shift
    always_comb
    begin
        addend    = p_reg[0] ? {1'b0, a_reg} : '0;
        upper     = p_reg[2*WIDTH:WIDTH] + addend;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(WIDTH - 1);
            a_next    = operand;
            p_next    = {{(WIDTH + 1){1'b0}}, operand};
        end
        else if (busy_reg)
        begin
            p_next   = {1'b0, upper, p_reg[WIDTH-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial product
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign done    = done_reg;
    assign product = p_reg[2*WIDTH-1:0];

endmodule

@@ hw/rtl/sws_serial_div.sv @@
// ============================================================================
// Bit-serial divider
// Restoring division, one quotient bit per cycle, quotient shifted into
// the dividend register.
// ============================================================================
module sws_serial_div
    import sws_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_BITS-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    trial_sub;
    logic                     fits;

    // Bring down the next dividend bit and try to subtract the divisor
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIVIDEND_BITS - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            dvd_next = {dvd_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ hw/rtl/stopwatch_with_running_stats.sv @@
// ============================================================================
// Stopwatch with running statistics
// Takes start/stop/pause/resume/clear events with time-of-day stamps, keeps
// the elapsed time and folds each stop into a running mean and mean square.
// ============================================================================
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-----------------------------------------
//  input    | s_tvalid / s_tready | s_tuser opcode, s_tdata time stamp
//  output   | m_tvalid / m_tready | m_tdata ok, elapsed, mean, mean square,
//           |                     | sample count
//
//  A result is offered after its beat passes the span and apply steps; an
//  accepted stop also runs the bit-serial squarer, then the two bit-serial
//  dividers side by side, and the fold before its result is offered.
//  One event is in work at a time; s_tready returns in the cycle the result is
//  offered, even while that result still waits in the output register.
//  Reset clears all watch and statistics state; no result is pending.
//
module stopwatch_with_running_stats
    import sws_pkg::*;
#(
    parameter int ELAPSED_BITS   = 32,
    parameter int MEAN_FRAC_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [OPCODE_BITS-1:0]   s_tuser,   // opcode
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // now_seconds, now_micros, zero pad
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata    // ok, elapsed_us, mean_us,
                                                // mean_square, sample_count, zero pad
);

    localparam int SUM_BITS = SPAN_BITS + 1;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    fsm_state_t state_reg, state_next;
    sws_ctl_t   ctl;

    // Event beat
    op_t                    op_reg;
    logic [SECS_BITS-1:0]   now_s_reg;
    logic [MICROS_BITS-1:0] now_us_reg;

    // Watch state
    logic                    running_reg, running_next;
    logic                    held_reg, held_next;
    logic [SECS_BITS-1:0]    start_s_reg, start_s_next;
    logic [MICROS_BITS-1:0]  start_us_reg, start_us_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;
    logic [MEAN_BITS-1:0]    mean_reg, mean_next;
    logic [SQUARE_BITS-1:0]  square_reg, square_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    ok_reg, ok_next;

    // Datapath between steps
    logic [SPAN_BITS-1:0]    span_reg, span_next;
    logic                    mean_up_reg, mean_up_next;
    logic                    sq_up_reg, sq_up_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic                        out_ok_reg;
    logic [OUT_ELAPSED_BITS-1:0] out_elapsed_reg;
    logic [MEAN_BITS-1:0]        out_mean_reg;
    logic [SQUARE_BITS-1:0]      out_square_reg;
    logic [COUNT_BITS-1:0]       out_count_reg;

    logic stop_taken;

    // Interval
    logic signed [SECS_DIFF_BITS-1:0]   secs_diff;
    logic signed [MICROS_DIFF_BITS-1:0] micros_diff;
    logic signed [SPAN_CALC_BITS-1:0]   secs_ext;
    logic signed [SPAN_CALC_BITS-1:0]   micros_ext;
    logic signed [SPAN_CALC_BITS-1:0]   us_total;

    // Elapsed accumulate
    logic [SUM_BITS-1:0]     elapsed_sum;
    logic [ELAPSED_BITS-1:0] elapsed_added;

    // Statistics
    logic                        sqr_done;
    logic [2*ELAPSED_BITS-1:0]   sqr_product;
    logic [DIVIDEND_BITS-1:0]    mean_target;
    logic [DIVIDEND_BITS-1:0]    mean_wide;
    logic [SQUARE_BITS-1:0]      sq_target;
    logic [DIVIDEND_BITS-1:0]    mean_dvd;
    logic [DIVIDEND_BITS-1:0]    sq_dvd;
    logic                        mean_div_done;
    logic                        sq_div_done;
    logic [DIVIDEND_BITS-1:0]    mean_q;
    logic [DIVIDEND_BITS-1:0]    sq_q;
    logic [DIVIDEND_BITS:0]      mean_up_sum;

    assign stop_taken = (op_reg == OP_STOP) && running_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SPAN;
            end
            ST_SPAN:  state_next = ST_APPLY;
            ST_APPLY: state_next = stop_taken ? ST_MUL : ST_DONE;
            ST_MUL:
            begin
                if (sqr_done)
                    state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (mean_div_done && sq_div_done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:  ctl.in_ready  = 1'b1;
            ST_SPAN:  ctl.span_en   = 1'b1;
            ST_APPLY:
            begin
                ctl.apply_en  = 1'b1;
                ctl.mul_start = stop_taken;
            end
            ST_DIFF:  ctl.div_start = 1'b1;
            ST_FOLD:  ctl.fold_en   = 1'b1;
            ST_DONE:  ctl.out_load  = !out_valid_reg || m_tready;
            default:  ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Latch the event beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && ctl.in_ready)
        begin
            op_reg     <= op_t'(s_tuser);
            now_s_reg  <= s_tdata[SECS_BITS-1:0];
            now_us_reg <= s_tdata[SECS_BITS+MICROS_BITS-1:SECS_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Interval since the start stamp, wrapped across midnight, floored at 0
    // ------------------------------------------------------------------
    always_comb
    begin
        secs_diff = $signed({2'b00, now_s_reg}) - $signed({2'b00, start_s_reg});
        if (now_s_reg < start_s_reg)
            secs_diff = secs_diff + DAY_SECS;
        micros_diff = $signed({1'b0, now_us_reg}) - $signed({1'b0, start_us_reg});
        secs_ext    = SPAN_CALC_BITS'(secs_diff);
        micros_ext  = SPAN_CALC_BITS'(micros_diff);
        us_total    = secs_ext * US_PER_SEC + micros_ext;
        span_next   = span_reg;
        if (ctl.span_en)
            span_next = us_total[SPAN_CALC_BITS-1] ? '0 : us_total[SPAN_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
    end

    // Add the interval to the elapsed total, saturating
    always_comb
    begin
        elapsed_sum   = SUM_BITS'(elapsed_reg) + SUM_BITS'(span_reg);
        elapsed_added = (elapsed_sum[SUM_BITS-1:ELAPSED_BITS] != '0)
                        ? ELAPSED_MAX : elapsed_sum[ELAPSED_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Event decode and watch state update
    // ------------------------------------------------------------------
    always_comb
    begin
        running_next  = running_reg;
        held_next     = held_reg;
        start_s_next  = start_s_reg;
        start_us_next = start_us_reg;
        elapsed_next  = elapsed_reg;
        count_next    = count_reg;
        ok_next       = ok_reg;
        if (ctl.apply_en)
        begin
            ok_next = 1'b1;
            unique case (op_reg)
                OP_START:
                begin
                    running_next  = 1'b1;
                    held_next     = 1'b0;
                    elapsed_next  = '0;
                    start_s_next  = now_s_reg;
                    start_us_next = now_us_reg;
                end
                OP_STOP:
                begin
                    if (!running_reg)
                        ok_next = 1'b0;
                    else
                    begin
                        running_next = 1'b0;
                        if (!held_reg)
                            elapsed_next = elapsed_added;
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                end
                OP_PAUSE:
                begin
                    if (held_reg || !running_reg)
                        ok_next = 1'b0;
                    else
                    begin
                        held_next    = 1'b1;
                        elapsed_next = elapsed_added;
                    end
                end
                OP_RESUME:
                begin
                    if (!running_reg)
                    begin
                        running_next  = 1'b1;
                        held_next     = 1'b0;
                        elapsed_next  = '0;
                        start_s_next  = now_s_reg;
                        start_us_next = now_us_reg;
                    end
                    else if (held_reg)
                    begin
                        held_next     = 1'b0;
                        start_s_next  = now_s_reg;
                        start_us_next = now_us_reg;
                    end
                end
                OP_CLEAR:
                begin
                    if (!running_reg)
                        elapsed_next = '0;
                end
                default:  ok_next = 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Statistics: square, distance to target, divide by count, fold back
    // ------------------------------------------------------------------
    sws_serial_sqr #(
        .WIDTH (ELAPSED_BITS)
    ) u_sqr (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.mul_start),
        .operand (elapsed_next),
        .done    (sqr_done),
        .product (sqr_product)
    );

    always_comb
    begin
        mean_target  = DIVIDEND_BITS'(elapsed_reg) << MEAN_FRAC_BITS;
        mean_wide    = DIVIDEND_BITS'(mean_reg);
        sq_target    = SQUARE_BITS'(sqr_product);
        mean_up_next = mean_up_reg;
        sq_up_next   = sq_up_reg;
        if (ctl.div_start)
        begin
            mean_up_next = (mean_target >= mean_wide);
            sq_up_next   = (sq_target >= square_reg);
        end
        mean_dvd = (mean_target >= mean_wide) ? (mean_target - mean_wide)
                                              : (mean_wide - mean_target);
        sq_dvd   = (sq_target >= square_reg) ? (sq_target - square_reg)
                                             : (square_reg - sq_target);
    end

    sws_serial_div u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (mean_dvd),
        .divisor  (count_reg),
        .done     (mean_div_done),
        .quotient (mean_q)
    );

    sws_serial_div u_sq_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (sq_dvd),
        .divisor  (count_reg),
        .done     (sq_div_done),
        .quotient (sq_q)
    );

    // Move each accumulator toward its target by the quotient
    always_comb
    begin
        mean_up_sum = {1'b0, mean_wide} + {1'b0, mean_q};
        mean_next   = mean_reg;
        square_next = square_reg;
        if (ctl.fold_en)
        begin
            if (mean_up_reg)
                mean_next = (mean_up_sum[DIVIDEND_BITS:MEAN_BITS] != '0)
                            ? MEAN_MAX : mean_up_sum[MEAN_BITS-1:0];
            else
                mean_next = mean_reg - mean_q[MEAN_BITS-1:0];
            if (sq_up_reg)
                square_next = square_reg + sq_q;
            else
                square_next = square_reg - sq_q;
        end
    end

    // Watch and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            held_reg     <= 1'b0;
            start_s_reg  <= '0;
            start_us_reg <= '0;
            elapsed_reg  <= '0;
            mean_reg     <= '0;
            square_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            running_reg  <= running_next;
            held_reg     <= held_next;
            start_s_reg  <= start_s_next;
            start_us_reg <= start_us_next;
            elapsed_reg  <= elapsed_next;
            mean_reg     <= mean_next;
            square_reg   <= square_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg      <= ok_next;
        mean_up_reg <= mean_up_next;
        sq_up_reg   <= sq_up_next;
    end

    // ------------------------------------------------------------------
    // Output register: load a finished result, drop valid once taken
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_ok_reg      <= ok_reg;
            out_elapsed_reg <= OUT_ELAPSED_BITS'(elapsed_reg);
            out_mean_reg    <= mean_reg;
            out_square_reg  <= square_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - OUT_RAW_BITS){1'b0}}, out_count_reg,
                       out_square_reg, out_mean_reg, out_elapsed_reg, out_ok_reg};

endmodule

@@ hw/rtl/sws_checker.sv @@
// ============================================================================
// Stopwatch port checker
// Watches the stream ports of the stopwatch over time.
// ============================================================================
`include "stopwatch_with_running_stats_defines.svh"

module sws_checker
    import sws_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata
);

    // A stalled result beat stays offered
    `SWS_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "beat dropped in stall")

    // A stalled result beat keeps its payload
    `SWS_ASSERT_CLK(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "payload changed")

    // One event in work at a time: ready drops right after an accepted beat
    `SWS_ASSERT_CLK(a_one_in_work, s_tvalid && s_tready |=> !s_tready, "input taken while busy")

    // No result is offered while reset is applied
    `SWS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result offered during reset")

endmodule

bind stopwatch_with_running_stats sws_checker u_sws_checker (.*);
